FILE: sv/adaptive_touch_speed_scaler_core_assert.svh
// Assertion macros shared by the speed scaler RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ADAPTIVE_TOUCH_SPEED_SCALER_CORE_ASSERT_SVH
`define ADAPTIVE_TOUCH_SPEED_SCALER_CORE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define ATSS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("speed scaler assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define ATSS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("speed scaler assertion failed");

`endif

FILE: sv/atss_pkg.sv
// Package for the adaptive touch speed scaler: state, step and register codes,
// command and status bundles. Depends on nothing.
`timescale 1ns / 1ps

package atss_pkg;

    localparam int PCT_BITS = 16;
    localparam int PCT_ONE  = 16384;

    localparam int EDGE_MIN  = 0;
    localparam int EDGE_ZERO = 1;
    localparam int EDGE_MAX  = 2;

    typedef enum logic [1:0] {
        REG_EDGE_MIN_X = 2'd0,
        REG_EDGE_MAX_X = 2'd1,
        REG_EDGE_MIN_Y = 2'd2,
        REG_EDGE_MAX_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_MORE = 2'd2
    } cnt_t;

    typedef enum logic [1:0] {
        STEP_ZERO_IN,
        STEP_ZERO_OUT,
        STEP_FAR_EDGE,
        STEP_PCT
    } step_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RF_CHECK,
        ST_S1_GO,
        ST_S1_WAIT,
        ST_S2_GO,
        ST_S2_WAIT,
        ST_COMMIT,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MQ_IDLE,
        MQ_MUL,
        MQ_DIV,
        MQ_FIN
    } mq_state_t;

    typedef struct packed {
        logic  capture;
        logic  init;
        logic  advance;
        logic  commit;
        logic  axis_clr;
        logic  axis_next;
        logic  start;
        step_t step;
        logic  finish;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic init_point;
        logic repeat_point;
        logic toward;
        logic reframe;
        logic axis;
        logic mq_done;
    } status_t;

endpackage

FILE: sv/atss_if.sv
// Stream interfaces of the speed scaler: touch points in, speed percentages out.
// Depends on atss_pkg for the percentage width.
`timescale 1ns / 1ps

interface atss_point_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  first_point;

    modport source(output valid, pos_x, pos_y, first_point, input ready);
    modport sink(input valid, pos_x, pos_y, first_point, output ready);
endinterface

interface atss_speed_if;
    logic                                valid;
    logic                                ready;
    logic signed [atss_pkg::PCT_BITS-1:0] percent_x;
    logic signed [atss_pkg::PCT_BITS-1:0] percent_y;
    logic                                saturated;

    modport source(output valid, percent_x, percent_y, saturated, input ready);
    modport sink(input valid, percent_x, percent_y, saturated, output ready);
endinterface

FILE: sv/atss_mulquot.sv
// Iterative signed multiply-divide unit: trunc(a*b/d), clamped to the quotient limit.
// Depends on atss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "adaptive_touch_speed_scaler_core_assert.svh"

module atss_mulquot #(
    parameter int OW = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 zero,
    input  logic signed [OW-1:0] a,
    input  logic signed [OW-1:0] b,
    input  logic signed [OW-1:0] d,
    output logic                 done,
    output logic signed [OW-1:0] q,
    output logic                 sat
);

    localparam int MB = OW - 1;
    localparam int H  = (MB + 1) / 2;
    localparam int AW = 4 * H;
    localparam int PB = 2 * MB;
    localparam int CW = $clog2(PB);
    localparam logic signed [OW-1:0] QL_S = {1'b0, {(OW-3){1'b1}}, 2'b00};
    localparam logic [PB-1:0] QL_P = {{(PB-OW){1'b0}}, QL_S};

    atss_pkg::mq_state_t st_reg, st_next;

    logic [2*H-1:0]   ua_reg, ub_reg;
    logic [MB-1:0]    ud_reg;
    logic             neg_reg;
    logic [AW-1:0]    acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic [MB-1:0]    rem_reg;
    logic [PB-1:0]    quo_reg;
    logic             done_reg;
    logic signed [OW-1:0] q_reg;
    logic             sat_reg;

    logic [MB-1:0]    ua, ub, ud;
    logic             neg;
    logic [H-1:0]     ah, bh;
    logic [2*H-1:0]   pp;
    logic [AW-1:0]    pp_sh;
    logic [MB:0]      rtry;
    logic             qb;
    logic [MB:0]      rsub;
    logic signed [OW-1:0] qmag;

    function automatic logic [MB-1:0] mag(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] t;
        begin
            t = v[OW-1] ? -v : v;
            mag = t[MB-1:0];
        end
    endfunction

    always_comb
    begin
        ua   = mag(a);
        ub   = mag(b);
        ud   = mag(d);
        neg  = a[OW-1] ^ b[OW-1] ^ d[OW-1];
        ah   = cnt_reg[0] ? ua_reg[2*H-1:H] : ua_reg[H-1:0];
        bh   = cnt_reg[1] ? ub_reg[2*H-1:H] : ub_reg[H-1:0];
        pp   = ah * bh;
        if (cnt_reg[0] && cnt_reg[1])
        begin
            pp_sh = {pp, {(2*H){1'b0}}};
        end
        else if (cnt_reg[0] || cnt_reg[1])
        begin
            pp_sh = {{H{1'b0}}, pp, {H{1'b0}}};
        end
        else
        begin
            pp_sh = {{(2*H){1'b0}}, pp};
        end
        rtry = {rem_reg, acc_reg[PB-1]};
        qb   = rtry >= {1'b0, ud_reg};
        rsub = qb ? rtry - {1'b0, ud_reg} : rtry;
        qmag = (quo_reg > QL_P) ? QL_S : {1'b0, quo_reg[OW-2:0]};
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            atss_pkg::MQ_IDLE:
            begin
                if (start && !zero && ua != '0 && ub != '0 && ud != '0)
                begin
                    st_next = atss_pkg::MQ_MUL;
                end
            end
            atss_pkg::MQ_MUL:
            begin
                if (cnt_reg[1:0] == 2'b11)
                begin
                    st_next = atss_pkg::MQ_DIV;
                end
            end
            atss_pkg::MQ_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = atss_pkg::MQ_FIN;
                end
            end
            atss_pkg::MQ_FIN:
            begin
                st_next = atss_pkg::MQ_IDLE;
            end
            default:
            begin
                st_next = atss_pkg::MQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= atss_pkg::MQ_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= 1'b0;
            case (st_reg)
                atss_pkg::MQ_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg <= '0;
                        if (zero || ua == '0 || ub == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else if (ud == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                atss_pkg::MQ_MUL:
                begin
                    if (cnt_reg[1:0] == 2'b11)
                    begin
                        cnt_reg <= CW'(PB - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                atss_pkg::MQ_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                atss_pkg::MQ_FIN:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            atss_pkg::MQ_IDLE:
            begin
                if (start)
                begin
                    ua_reg  <= {{(2*H-MB){1'b0}}, ua};
                    ub_reg  <= {{(2*H-MB){1'b0}}, ub};
                    ud_reg  <= ud;
                    neg_reg <= neg;
                    acc_reg <= '0;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    if (zero || ua == '0 || ub == '0)
                    begin
                        q_reg   <= '0;
                        sat_reg <= !zero && (ud == '0);
                    end
                    else if (ud == '0)
                    begin
                        q_reg   <= neg ? -QL_S : QL_S;
                        sat_reg <= 1'b1;
                    end
                end
            end
            atss_pkg::MQ_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
            end
            atss_pkg::MQ_DIV:
            begin
                acc_reg <= {acc_reg[AW-2:0], 1'b0};
                rem_reg <= rsub[MB-1:0];
                quo_reg <= {quo_reg[PB-2:0], qb};
            end
            atss_pkg::MQ_FIN:
            begin
                q_reg   <= neg_reg ? -qmag : qmag;
                sat_reg <= quo_reg > QL_P;
            end
            default:
            begin
                q_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign sat  = sat_reg;

    `ATSS_ASSERT_IMP(mq_start_when_idle, clk, rst_n, start, st_reg == atss_pkg::MQ_IDLE)
    `ATSS_ASSERT_NEXT(mq_done_single, clk, rst_n, done_reg, !done_reg)
    `ATSS_ASSERT_IMP(mq_sat_value, clk, rst_n, done_reg && sat_reg, q_reg == QL_S || q_reg == -QL_S || q_reg == '0)

endmodule

FILE: sv/atss_ctrl.sv
// Controller of the speed scaler: sequences edge rebuilds and percentages
// and runs the point and result handshakes. Depends on atss_pkg.
`timescale 1ns / 1ps

module atss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  atss_pkg::status_t status,
    output atss_pkg::cmd_t    cmd
);

    atss_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atss_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.step   = atss_pkg::STEP_PCT;
        in_ready   = 1'b0;
        unique case (state_reg)
            atss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = atss_pkg::ST_DECIDE;
                end
            end
            atss_pkg::ST_DECIDE:
            begin
                cmd.axis_clr = 1'b1;
                if (status.init_point)
                begin
                    cmd.init   = 1'b1;
                    state_next = atss_pkg::ST_PCT_GO;
                end
                else if (status.repeat_point)
                begin
                    state_next = atss_pkg::ST_PCT_GO;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = atss_pkg::ST_RF_CHECK;
                end
            end
            atss_pkg::ST_RF_CHECK:
            begin
                if (status.reframe)
                begin
                    state_next = atss_pkg::ST_S1_GO;
                end
                else if (status.axis)
                begin
                    state_next = atss_pkg::ST_COMMIT;
                end
                else
                begin
                    cmd.axis_next = 1'b1;
                end
            end
            atss_pkg::ST_S1_GO:
            begin
                cmd.start  = 1'b1;
                cmd.step   = status.toward ? atss_pkg::STEP_ZERO_IN : atss_pkg::STEP_ZERO_OUT;
                state_next = atss_pkg::ST_S1_WAIT;
            end
            atss_pkg::ST_S1_WAIT:
            begin
                if (status.mq_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = atss_pkg::ST_S2_GO;
                end
            end
            atss_pkg::ST_S2_GO:
            begin
                cmd.start  = 1'b1;
                cmd.step   = atss_pkg::STEP_FAR_EDGE;
                state_next = atss_pkg::ST_S2_WAIT;
            end
            atss_pkg::ST_S2_WAIT:
            begin
                if (status.mq_done)
                begin
                    cmd.finish = 1'b1;
                    if (status.axis)
                    begin
                        state_next = atss_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        cmd.axis_next = 1'b1;
                        state_next    = atss_pkg::ST_RF_CHECK;
                    end
                end
            end
            atss_pkg::ST_COMMIT:
            begin
                cmd.commit   = 1'b1;
                cmd.axis_clr = 1'b1;
                state_next   = atss_pkg::ST_PCT_GO;
            end
            atss_pkg::ST_PCT_GO:
            begin
                cmd.start  = 1'b1;
                cmd.step   = atss_pkg::STEP_PCT;
                state_next = atss_pkg::ST_PCT_WAIT;
            end
            atss_pkg::ST_PCT_WAIT:
            begin
                if (status.mq_done)
                begin
                    cmd.finish = 1'b1;
                    if (status.axis)
                    begin
                        state_next = atss_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.axis_next = 1'b1;
                        state_next    = atss_pkg::ST_PCT_GO;
                    end
                end
            end
            atss_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = atss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/atss_datapath.sv
// Datapath of the speed scaler: configuration, scale edges, operand selection,
// edge clamping and the result register. Depends on atss_pkg and atss_mulquot.
`timescale 1ns / 1ps

module atss_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic [COORD_BITS-1:0]                pos_x,
    input  logic [COORD_BITS-1:0]                pos_y,
    input  logic                                 first_point,
    input  atss_pkg::cmd_t                       cmd,
    output atss_pkg::status_t                    status,
    output logic signed [atss_pkg::PCT_BITS-1:0] percent_x,
    output logic signed [atss_pkg::PCT_BITS-1:0] percent_y,
    output logic                                 saturated
);

    localparam int EW = COORD_BITS + FRAC_BITS + 4;
    localparam int OW = EW + 2;
    localparam int SW = EW + 3;
    localparam int PW = atss_pkg::PCT_BITS;
    localparam logic [COORD_BITS-1:0] EMAX_RESET = COORD_BITS'(4095);
    localparam logic signed [SW-1:0] LIM_S = {4'b0000, {(EW-1){1'b1}}};
    localparam logic signed [OW-1:0] PCT_ONE_W = OW'(atss_pkg::PCT_ONE);

    logic [COORD_BITS-1:0] emin_x_reg, emax_x_reg, emin_y_reg, emax_y_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg, last_x_reg, last_y_reg;
    logic                  first_reg;
    logic                  dir_x_reg, dir_y_reg, rf_x_reg, rf_y_reg, axis_reg;
    atss_pkg::cnt_t        cnt_reg;
    logic signed [EW-1:0]  sx_reg [3];
    logic signed [EW-1:0]  sy_reg [3];
    logic signed [EW-1:0]  nz_reg;
    atss_pkg::step_t       step_reg;
    logic                  sat_reg;
    logic signed [PW-1:0]  pct_x_reg, pct_y_reg;
    logic signed [PW-1:0]  out_x_reg, out_y_reg;
    logic                  out_sat_reg;

    logic                  larger, nx, ny, lower, clip;
    logic signed [EW-1:0]  p_rf, p_pt, mn, z, mx, emn, emx, en, far, near, edge_res;
    logic signed [OW-1:0]  p_w, pp_w, z_w, mn_w, mx_w, en_w, far_w, near_w, nz_w;
    logic signed [OW-1:0]  mq_a, mq_b, mq_d, mq_q, pct_t;
    logic                  mq_zero, mq_done, mq_sat;
    logic signed [SW-1:0]  sum;
    logic signed [PW-1:0]  pct_res;

    function automatic logic signed [EW-1:0] to_q(input logic [COORD_BITS-1:0] c);
        to_q = {4'b0000, c, {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic signed [OW-1:0] ext(input logic signed [EW-1:0] v);
        ext = {{2{v[EW-1]}}, v};
    endfunction

    always_comb
    begin
        larger = axis_reg ? dir_y_reg : dir_x_reg;
        mn     = axis_reg ? sy_reg[atss_pkg::EDGE_MIN]  : sx_reg[atss_pkg::EDGE_MIN];
        z      = axis_reg ? sy_reg[atss_pkg::EDGE_ZERO] : sx_reg[atss_pkg::EDGE_ZERO];
        mx     = axis_reg ? sy_reg[atss_pkg::EDGE_MAX]  : sx_reg[atss_pkg::EDGE_MAX];
        p_rf   = to_q(axis_reg ? last_y_reg : last_x_reg);
        p_pt   = to_q(axis_reg ? y_reg : x_reg);
        emn    = to_q(axis_reg ? emin_y_reg : emin_x_reg);
        emx    = to_q(axis_reg ? emax_y_reg : emax_x_reg);
        en     = larger ? emx : emn;
        far    = larger ? mn : mx;
        near   = larger ? mx : mn;
        p_w    = ext(p_rf);
        pp_w   = ext(p_pt);
        z_w    = ext(z);
        mn_w   = ext(mn);
        mx_w   = ext(mx);
        en_w   = ext(en);
        far_w  = ext(far);
        near_w = ext(near);
        nz_w   = ext(nz_reg);
        lower  = pp_w < z_w;
        nx     = !(x_reg < last_x_reg);
        ny     = !(y_reg < last_y_reg);
    end

    always_comb
    begin
        case (cmd.step)
            atss_pkg::STEP_ZERO_IN:
            begin
                mq_a    = en_w - p_w;
                mq_b    = p_w - z_w;
                mq_d    = (far_w - z_w) + (p_w - z_w);
                mq_zero = far == z;
            end
            atss_pkg::STEP_ZERO_OUT:
            begin
                mq_a    = z_w - p_w;
                mq_b    = en_w - p_w;
                mq_d    = near_w - p_w;
                mq_zero = near == z;
            end
            atss_pkg::STEP_FAR_EDGE:
            begin
                mq_a    = far_w - p_w;
                mq_b    = nz_w - p_w;
                mq_d    = z_w - p_w;
                mq_zero = z == far;
            end
            default:
            begin
                mq_a    = pp_w - z_w;
                mq_b    = PCT_ONE_W;
                mq_d    = (lower ? mn_w : mx_w) - z_w;
                mq_zero = mq_d == '0;
            end
        endcase
    end

    atss_mulquot #(
        .OW(OW)
    ) u_mulquot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .zero  (mq_zero),
        .a     (mq_a),
        .b     (mq_b),
        .d     (mq_d),
        .done  (mq_done),
        .q     (mq_q),
        .sat   (mq_sat)
    );

    always_comb
    begin
        sum = {p_w[OW-1], p_w} + {mq_q[OW-1], mq_q};
        if (sum > LIM_S)
        begin
            edge_res = LIM_S[EW-1:0];
            clip     = 1'b1;
        end
        else if (sum < -LIM_S)
        begin
            edge_res = -LIM_S[EW-1:0];
            clip     = 1'b1;
        end
        else
        begin
            edge_res = sum[EW-1:0];
            clip     = 1'b0;
        end
        pct_t = lower ? -mq_q : mq_q;
        if (pct_t > PCT_ONE_W)
        begin
            pct_res = PCT_ONE_W[PW-1:0];
        end
        else if (pct_t < -PCT_ONE_W)
        begin
            pct_res = -PCT_ONE_W[PW-1:0];
        end
        else
        begin
            pct_res = pct_t[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emin_x_reg <= '0;
            emax_x_reg <= EMAX_RESET;
            emin_y_reg <= '0;
            emax_y_reg <= EMAX_RESET;
            last_x_reg <= '0;
            last_y_reg <= '0;
            dir_x_reg  <= 1'b0;
            dir_y_reg  <= 1'b0;
            rf_x_reg   <= 1'b0;
            rf_y_reg   <= 1'b0;
            axis_reg   <= 1'b0;
            cnt_reg    <= atss_pkg::CNT_NONE;
            step_reg   <= atss_pkg::STEP_PCT;
            for (int i = 0; i < 3; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    atss_pkg::REG_EDGE_MIN_X: emin_x_reg <= cfg_data;
                    atss_pkg::REG_EDGE_MAX_X: emax_x_reg <= cfg_data;
                    atss_pkg::REG_EDGE_MIN_Y: emin_y_reg <= cfg_data;
                    atss_pkg::REG_EDGE_MAX_Y: emax_y_reg <= cfg_data;
                    default: emin_x_reg <= emin_x_reg;
                endcase
            end
            if (cmd.axis_clr)
            begin
                axis_reg <= 1'b0;
            end
            else if (cmd.axis_next)
            begin
                axis_reg <= 1'b1;
            end
            if (cmd.start)
            begin
                step_reg <= cmd.step;
            end
            if (cmd.init)
            begin
                sx_reg[atss_pkg::EDGE_MIN]  <= to_q(emin_x_reg);
                sx_reg[atss_pkg::EDGE_ZERO] <= to_q(x_reg);
                sx_reg[atss_pkg::EDGE_MAX]  <= to_q(emax_x_reg);
                sy_reg[atss_pkg::EDGE_MIN]  <= to_q(emin_y_reg);
                sy_reg[atss_pkg::EDGE_ZERO] <= to_q(y_reg);
                sy_reg[atss_pkg::EDGE_MAX]  <= to_q(emax_y_reg);
                cnt_reg    <= atss_pkg::CNT_ONE;
                last_x_reg <= x_reg;
                last_y_reg <= y_reg;
            end
            if (cmd.advance)
            begin
                rf_x_reg  <= (cnt_reg == atss_pkg::CNT_MORE) && (dir_x_reg != nx);
                rf_y_reg  <= (cnt_reg == atss_pkg::CNT_MORE) && (dir_y_reg != ny);
                dir_x_reg <= nx;
                dir_y_reg <= ny;
            end
            if (cmd.commit)
            begin
                cnt_reg    <= atss_pkg::CNT_MORE;
                last_x_reg <= x_reg;
                last_y_reg <= y_reg;
            end
            if (cmd.finish && step_reg == atss_pkg::STEP_FAR_EDGE)
            begin
                if (axis_reg)
                begin
                    sy_reg[atss_pkg::EDGE_ZERO] <= nz_reg;
                    sy_reg[atss_pkg::EDGE_MIN]  <= larger ? edge_res : en;
                    sy_reg[atss_pkg::EDGE_MAX]  <= larger ? en : edge_res;
                end
                else
                begin
                    sx_reg[atss_pkg::EDGE_ZERO] <= nz_reg;
                    sx_reg[atss_pkg::EDGE_MIN]  <= larger ? edge_res : en;
                    sx_reg[atss_pkg::EDGE_MAX]  <= larger ? en : edge_res;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            first_reg <= first_point;
            sat_reg   <= 1'b0;
        end
        if (cmd.finish)
        begin
            case (step_reg)
                atss_pkg::STEP_PCT:
                begin
                    if (axis_reg)
                    begin
                        pct_y_reg <= pct_res;
                    end
                    else
                    begin
                        pct_x_reg <= pct_res;
                    end
                end
                atss_pkg::STEP_FAR_EDGE:
                begin
                    sat_reg <= sat_reg | mq_sat | clip;
                end
                default:
                begin
                    nz_reg  <= edge_res;
                    sat_reg <= sat_reg | mq_sat | clip;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_x_reg   <= pct_x_reg;
            out_y_reg   <= pct_y_reg;
            out_sat_reg <= sat_reg;
        end
    end

    always_comb
    begin
        status.init_point   = first_reg || (cnt_reg == atss_pkg::CNT_NONE);
        status.repeat_point = (x_reg == last_x_reg) && (y_reg == last_y_reg);
        status.toward       = larger ? (p_w < z_w) : (z_w < p_w);
        status.reframe      = axis_reg ? rf_y_reg : rf_x_reg;
        status.axis         = axis_reg;
        status.mq_done      = mq_done;
    end

    assign percent_x = out_x_reg;
    assign percent_y = out_y_reg;
    assign saturated = out_sat_reg;

endmodule

FILE: sv/adaptive_touch_speed_scaler_core.sv
// Top level of the adaptive touch speed scaler: controller, datapath and ports.
// Depends on atss_pkg, atss_if, atss_ctrl and atss_datapath.
//
//   channel  direction  handshake            payload
//   point    in         valid/ready          pos_x, pos_y, first_point
//   speed    out        valid/ready          percent_x, percent_y, saturated
//   cfg      in         cfg_we (no wait)     cfg_index, cfg_data
//
// Each quotient runs in one multiply-divide unit: four partial products, then a
// restoring divider of one bit per cycle, 2*(COORD_BITS+FRAC_BITS+5) steps (66 by default).
// An item takes two quotients plus two more per axis that reverses.
// A new point is taken while the previous result waits in the output register; a result
// stalled on the output side holds the controller before its next result load.
// Reset clears the scale, the direction state and the configuration to their defaults.
`timescale 1ns / 1ps

module adaptive_touch_speed_scaler_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    atss_point_if.sink            point,
    atss_speed_if.source          speed
);

    atss_pkg::cmd_t    cmd;
    atss_pkg::status_t status;

    atss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (speed.valid),
        .out_ready (speed.ready),
        .status    (status),
        .cmd       (cmd)
    );

    atss_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pos_x       (point.pos_x),
        .pos_y       (point.pos_y),
        .first_point (point.first_point),
        .cmd         (cmd),
        .status      (status),
        .percent_x   (speed.percent_x),
        .percent_y   (speed.percent_y),
        .saturated   (speed.saturated)
    );

endmodule
